[sv/thermistor_table_interpolate_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the thermistor table interpolator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_TABLE_INTERPOLATE_MACROS_SVH
`define THERMISTOR_TABLE_INTERPOLATE_MACROS_SVH

// Same-cycle implication
`define TTI_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tti_pkg.sv]
// ----------------------------------------------------------------------------
// tti_pkg
// Shared widths, codes, calibration ROM contents and divider status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tti_pkg;

    localparam int CODE_W      = 10;
    localparam int DIVIDER_W   = 20;
    localparam int TEMP_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int OHMS_W      = 32;
    localparam int ROM_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    // interpolation divide: ((hi - r) * 512 + d) / (2 * d)
    localparam int FRAC_NUM_W  = 26;
    localparam int FRAC_DEN_W  = 17;
    localparam int FRAC_Q_W    = 9;

    localparam int TABLE_ENTRIES_DEF      = 91;
    localparam int ADC_BITS_DEF           = 10;
    localparam int LOWEST_TEMPERATURE_DEF = -10;

    localparam logic [DIVIDER_W-1:0] DIVIDER_RESET = 20'd10000;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIVIDER_OHMS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULL_UP_MODE = 2'd1;

    localparam logic [STATUS_W-1:0] STAT_INTERP = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_COLD   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_HOT    = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Resistance in ohms at LOWEST_TEMPERATURE + addr degrees C.
    function automatic logic [ROM_W-1:0] rom_word(input logic [7:0] addr);
        logic [ROM_W-1:0] w;
        unique case (addr)
            8'd0:  w = 16'd44967;
            8'd1:  w = 16'd42897;
            8'd2:  w = 16'd40932;
            8'd3:  w = 16'd39066;
            8'd4:  w = 16'd37294;
            8'd5:  w = 16'd35611;
            8'd6:  w = 16'd34013;
            8'd7:  w = 16'd32494;
            8'd8:  w = 16'd31051;
            8'd9:  w = 16'd29679;
            8'd10: w = 16'd28375;
            8'd11: w = 16'd27135;
            8'd12: w = 16'd25956;
            8'd13: w = 16'd24834;
            8'd14: w = 16'd23766;
            8'd15: w = 16'd22750;
            8'd16: w = 16'd21783;
            8'd17: w = 16'd20862;
            8'd18: w = 16'd19985;
            8'd19: w = 16'd19150;
            8'd20: w = 16'd18345;
            8'd21: w = 16'd17595;
            8'd22: w = 16'd16872;
            8'd23: w = 16'd16183;
            8'd24: w = 16'd15526;
            8'd25: w = 16'd14899;
            8'd26: w = 16'd14301;
            8'd27: w = 16'd13730;
            8'd28: w = 16'd13186;
            8'd29: w = 16'd12666;
            8'd30: w = 16'd12169;
            8'd31: w = 16'd11695;
            8'd32: w = 16'd11242;
            8'd33: w = 16'd10809;
            8'd34: w = 16'd10395;
            8'd35: w = 16'd10000;
            8'd36: w = 16'd9622;
            8'd37: w = 16'd9260;
            8'd38: w = 16'd8914;
            8'd39: w = 16'd8583;
            8'd40: w = 16'd8267;
            8'd41: w = 16'd7963;
            8'd42: w = 16'd7673;
            8'd43: w = 16'd7395;
            8'd44: w = 16'd7129;
            8'd45: w = 16'd6874;
            8'd46: w = 16'd6629;
            8'd47: w = 16'd6395;
            8'd48: w = 16'd6170;
            8'd49: w = 16'd5955;
            8'd50: w = 16'd5748;
            8'd51: w = 16'd5550;
            8'd52: w = 16'd5360;
            8'd53: w = 16'd5177;
            8'd54: w = 16'd5002;
            8'd55: w = 16'd4834;
            8'd56: w = 16'd4672;
            8'd57: w = 16'd4517;
            8'd58: w = 16'd4368;
            8'd59: w = 16'd4225;
            8'd60: w = 16'd4087;
            8'd61: w = 16'd3955;
            8'd62: w = 16'd3827;
            8'd63: w = 16'd3705;
            8'd64: w = 16'd3587;
            8'd65: w = 16'd3474;
            8'd66: w = 16'd3365;
            8'd67: w = 16'd3260;
            8'd68: w = 16'd3159;
            8'd69: w = 16'd3062;
            8'd70: w = 16'd2968;
            8'd71: w = 16'd2878;
            8'd72: w = 16'd2791;
            8'd73: w = 16'd2707;
            8'd74: w = 16'd2626;
            8'd75: w = 16'd2548;
            8'd76: w = 16'd2473;
            8'd77: w = 16'd2401;
            8'd78: w = 16'd2331;
            8'd79: w = 16'd2264;
            8'd80: w = 16'd2199;
            8'd81: w = 16'd2136;
            8'd82: w = 16'd2075;
            8'd83: w = 16'd2017;
            8'd84: w = 16'd1960;
            8'd85: w = 16'd1906;
            8'd86: w = 16'd1853;
            8'd87: w = 16'd1802;
            8'd88: w = 16'd1753;
            8'd89: w = 16'd1705;
            8'd90: w = 16'd1659;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/tti_div.sv]
// ----------------------------------------------------------------------------
// tti_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tti_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 17
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    output tti_pkg::div_stat_t     stat,
    output logic      [NUM_W-1:0]  quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_sub;
    logic             qbit;
    logic [DEN_W-1:0] rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub   = rem_shift - {1'b0, den_reg};
        qbit      = (rem_shift >= {1'b0, den_reg});
        // remainder stays below the divisor, so it fits DEN_W bits either way
        rem_next  = qbit ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            count_reg <= CNT_W'(NUM_W);
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;

endmodule

`default_nettype wire

[sv/thermistor_table_interpolate.sv]
// ----------------------------------------------------------------------------
// thermistor_table_interpolate
// ADC code to thermistor resistance, table scan and linear interpolation.
// ----------------------------------------------------------------------------
// One word in, one word out. An interpolated item runs the shared serial
// divider (NUM_W = max(ADC_BITS+21, 26) bits wide, one quotient bit per
// cycle) once for the resistance and once for the interpolation fraction,
// and scans the calibration ROM from entry 0 up to k, the index of the first
// table entry below the resistance; each entry is read in ST_SCAN_RD and
// compared in ST_SCAN_CMP. Clamped readings skip the second divide, and a
// pull-down reading of code zero skips the first one as well. One item is
// in work at a time; a finished word waits in the output register while the
// next item is accepted. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "thermistor_table_interpolate_macros.svh"

module thermistor_table_interpolate #(
    parameter int TABLE_ENTRIES      = tti_pkg::TABLE_ENTRIES_DEF,
    parameter int ADC_BITS           = tti_pkg::ADC_BITS_DEF,
    parameter int LOWEST_TEMPERATURE = tti_pkg::LOWEST_TEMPERATURE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tti_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tti_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [tti_pkg::CODE_W-1:0]        adc_code,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [tti_pkg::TEMP_W-1:0]      temperature_q8,
    output logic [tti_pkg::STATUS_W-1:0]           range_status,
    output logic [tti_pkg::OHMS_W-1:0]             sensor_ohms
);

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FACT_W = ADC_BITS + 1;
    localparam int PROD_W = tti_pkg::DIVIDER_W + FACT_W;
    localparam int NUM_W  = (PROD_W > tti_pkg::FRAC_NUM_W) ? PROD_W : tti_pkg::FRAC_NUM_W;
    localparam int DEN_W  = (FACT_W > tti_pkg::FRAC_DEN_W) ? FACT_W : tti_pkg::FRAC_DEN_W;

    localparam logic [FACT_W-1:0] FULL_SCALE = {1'b1, {ADC_BITS{1'b0}}};
    localparam logic [tti_pkg::TEMP_W-1:0] COLD_Q8 =
        tti_pkg::TEMP_W'(LOWEST_TEMPERATURE * 256);
    localparam logic [tti_pkg::TEMP_W-1:0] HOT_Q8 =
        tti_pkg::TEMP_W'((LOWEST_TEMPERATURE + TABLE_ENTRIES - 1) * 256);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_ENTRIES - 1);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MUL      = 7'b0000010,
        ST_DIV_OHMS = 7'b0000100,
        ST_SCAN_RD  = 7'b0001000,
        ST_SCAN_CMP = 7'b0010000,
        ST_DIV_FRAC = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [tti_pkg::DIVIDER_W-1:0] divider_reg;
    logic                          pull_up_reg;

    logic [ADC_BITS-1:0]           code_reg;
    logic [tti_pkg::OHMS_W-1:0]    ohms_reg;
    logic [ADDR_W-1:0]             idx_reg;
    logic [tti_pkg::ROM_W-1:0]     rom_data_reg;
    logic [tti_pkg::ROM_W-1:0]     prev_reg;
    logic [tti_pkg::TEMP_W-1:0]    res_temp_reg;
    logic [tti_pkg::STATUS_W-1:0]  res_status_reg;

    logic                          out_valid_reg;
    logic [tti_pkg::TEMP_W-1:0]    out_temp_reg;
    logic [tti_pkg::STATUS_W-1:0]  out_status_reg;
    logic [tti_pkg::OHMS_W-1:0]    out_ohms_reg;

    logic [31:0]                   code_ext;
    logic [FACT_W-1:0]             code_wide;
    logic [FACT_W-1:0]             fact_num;
    logic [FACT_W-1:0]             fact_den;
    logic [PROD_W-1:0]             product;
    logic                          ohms_sat_early;
    logic [tti_pkg::ROM_W-1:0]     seg_span;
    logic [tti_pkg::ROM_W-1:0]     seg_diff;
    logic [tti_pkg::FRAC_NUM_W-1:0] frac_num;
    logic [tti_pkg::FRAC_DEN_W-1:0] frac_den;
    logic                          found;
    logic                          in_accept;
    logic                          out_load;
    logic                          div_start;
    logic [NUM_W-1:0]              div_num;
    logic [DEN_W-1:0]              div_den;
    tti_pkg::div_stat_t            div_stat;
    logic [NUM_W-1:0]              div_quot;
    logic [63:0]                   quot_ext;
    logic [31:0]                   interp_temp;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg <= tti_pkg::DIVIDER_RESET;
            pull_up_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == tti_pkg::CFG_DIVIDER_OHMS)
            begin
                divider_reg <= cfg_data[tti_pkg::DIVIDER_W-1:0];
            end
            else if (cfg_index == tti_pkg::CFG_PULL_UP_MODE)
            begin
                pull_up_reg <= cfg_data[0];
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        code_ext  = 32'(adc_code);
        code_wide = {1'b0, code_reg};
        fact_num  = pull_up_reg ? code_wide : (FULL_SCALE - code_wide);
        fact_den  = pull_up_reg ? (FULL_SCALE - code_wide) : code_wide;
        product   = PROD_W'(divider_reg) * PROD_W'(fact_num);
        ohms_sat_early = (fact_den == '0);

        found    = ({16'b0, rom_data_reg} < ohms_reg);
        seg_span = prev_reg - rom_data_reg;
        seg_diff = prev_reg - ohms_reg[tti_pkg::ROM_W-1:0];
        frac_num = tti_pkg::FRAC_NUM_W'({seg_diff, 9'b0})
                 + tti_pkg::FRAC_NUM_W'(seg_span);
        frac_den = {seg_span, 1'b0};

        div_start = ((state_reg == ST_MUL) && !ohms_sat_early)
                 || ((state_reg == ST_SCAN_CMP) && found && (idx_reg != '0));
        div_num   = (state_reg == ST_MUL) ? NUM_W'(product) : NUM_W'(frac_num);
        div_den   = (state_reg == ST_MUL) ? DEN_W'(fact_den) : DEN_W'(frac_den);

        quot_ext    = 64'(div_quot);
        interp_temp = ((32'(LOWEST_TEMPERATURE) + 32'(idx_reg) - 32'd1) << 8)
                    + 32'(div_quot[tti_pkg::FRAC_Q_W-1:0]);
    end

    tti_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // calibration ROM, registered read
    always_ff @(posedge clk)
    begin
        rom_data_reg <= tti_pkg::rom_word(8'(idx_reg));
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ohms_sat_early ? ST_SCAN_RD : ST_DIV_OHMS;
            end
            ST_DIV_OHMS:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (found)
                begin
                    state_next = (idx_reg == '0) ? ST_DONE : ST_DIV_FRAC;
                end
                else
                begin
                    state_next = (idx_reg == LAST_IDX) ? ST_DONE : ST_SCAN_RD;
                end
            end
            ST_DIV_FRAC:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL || state_reg == ST_DIV_OHMS)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == ST_SCAN_CMP && !found && idx_reg != LAST_IDX)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            code_reg <= code_ext[ADC_BITS-1:0];
        end
        if (state_reg == ST_MUL && ohms_sat_early)
        begin
            ohms_reg <= '1;
        end
        if (state_reg == ST_DIV_OHMS && div_stat.done)
        begin
            ohms_reg <= (quot_ext[63:32] != '0) ? '1 : quot_ext[31:0];
        end
        if (state_reg == ST_SCAN_CMP)
        begin
            // hold the entry above for the interpolation span
            prev_reg <= rom_data_reg;
            if (found && idx_reg == '0)
            begin
                res_temp_reg   <= COLD_Q8;
                res_status_reg <= tti_pkg::STAT_COLD;
            end
            else if (!found && idx_reg == LAST_IDX)
            begin
                res_temp_reg   <= HOT_Q8;
                res_status_reg <= tti_pkg::STAT_HOT;
            end
        end
        if (state_reg == ST_DIV_FRAC && div_stat.done)
        begin
            res_temp_reg   <= interp_temp[tti_pkg::TEMP_W-1:0];
            res_status_reg <= tti_pkg::STAT_INTERP;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_temp_reg   <= res_temp_reg;
            out_status_reg <= res_status_reg;
            out_ohms_reg   <= ohms_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign temperature_q8 = out_temp_reg;
    assign range_status   = out_status_reg;
    assign sensor_ohms    = out_ohms_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `TTI_ASSERT_HOLDS(a_cold_value, out_valid && range_status == tti_pkg::STAT_COLD, temperature_q8 == COLD_Q8, "cold clamp with wrong temperature")
    `TTI_ASSERT_HOLDS(a_hot_value, out_valid && range_status == tti_pkg::STAT_HOT, temperature_q8 == HOT_Q8, "hot clamp with wrong temperature")
    `TTI_ASSERT_HOLDS(a_scan_bound, state_reg == ST_SCAN_CMP, idx_reg <= LAST_IDX, "table scan ran past the last entry")
    `TTI_ASSERT_HOLDS(a_div_alive, state_reg == ST_DIV_OHMS || state_reg == ST_DIV_FRAC, div_stat.busy || div_stat.done, "waiting on an idle divider")
    `TTI_ASSERT_NEXT(a_accept_starts, in_accept, state_reg == ST_MUL, "accepted word did not start the multiply")

endmodule

`default_nettype wire
